FILE: design/assert_macros.svh
// Assertion macros for the checker file of this block.
// Depends on nothing; included by the checker file that holds the assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2cm assertion failed");

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("i2cm forbidden condition seen");

`endif

FILE: design/i2cm_pkg.sv
// Package of the I2C master byte engine: types, codes and reset constants.
// Depends on nothing; used by the interfaces, the register file, the sequencer and the top level.
package i2cm_pkg;

  localparam int BYTE_BITS  = 8;
  localparam int BIT_CNT_W  = $clog2(BYTE_BITS + 1);
  localparam int TICK_W     = 8;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [TICK_W-1:0] HALF_BIT_RST   = 8'd2;
  localparam logic [TICK_W-1:0] START_STOP_RST = 8'd4;
  localparam logic [TICK_W-1:0] ACK_SETUP_RST  = 8'd1;
  localparam logic [TICK_W-1:0] ACK_TMO_RST    = 8'd250;

  typedef enum logic [OP_W-1:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_BIT   = 2'd0,
    REG_START_STOP = 2'd1,
    REG_ACK_SETUP  = 2'd2,
    REG_ACK_TMO    = 2'd3
  } reg_e;

  typedef enum logic [14:0] {
    PH_IDLE = 15'h0001,
    PH_ST1  = 15'h0002,
    PH_ST2  = 15'h0004,
    PH_SP1  = 15'h0008,
    PH_SP2  = 15'h0010,
    PH_WLO1 = 15'h0020,
    PH_WHI  = 15'h0040,
    PH_WLO2 = 15'h0080,
    PH_A1   = 15'h0100,
    PH_A2   = 15'h0200,
    PH_POLL = 15'h0400,
    PH_RLO  = 15'h0800,
    PH_RHI  = 15'h1000,
    PH_K1   = 15'h2000,
    PH_K2   = 15'h4000
  } phase_e;

  typedef struct packed {
    logic [TICK_W-1:0] half_bit;
    logic [TICK_W-1:0] start_stop;
    logic [TICK_W-1:0] ack_setup;
    logic [TICK_W-1:0] ack_tmo;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [BYTE_BITS-1:0] tx_byte;
    logic                 send_ack;
    logic                 sda_in;
  } cmd_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_drive;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 ack_missing;
  } res_t;

endpackage

FILE: design/i2cm_if.sv
// Handshake channels of the I2C master byte engine: command in, line state out.
// Depends on i2cm_pkg for the field widths.
interface i2cm_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [i2cm_pkg::OP_W-1:0]      op;
  logic [i2cm_pkg::BYTE_BITS-1:0] tx_byte;
  logic                           send_ack;
  logic                           sda_in;

  modport source (output valid, op, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, op, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic                           valid;
  logic                           ready;
  logic                           scl_level;
  logic                           sda_level;
  logic                           sda_drive;
  logic                           busy_res;
  logic                           done_res;
  logic [i2cm_pkg::BYTE_BITS-1:0] rx_byte;
  logic                           ack_missing;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_missing, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_missing, output ready);
endinterface

FILE: design/i2cm_cfg.sv
// Timing register file of the I2C master byte engine.
// Depends on i2cm_pkg for the register indexes and reset values.
module i2cm_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]   idx_i,
  input  logic [i2cm_pkg::TICK_W-1:0]      wdata_i,
  output i2cm_pkg::cfg_t                   cfg_o
);

  i2cm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit   <= i2cm_pkg::HALF_BIT_RST;
      cfg_q.start_stop <= i2cm_pkg::START_STOP_RST;
      cfg_q.ack_setup  <= i2cm_pkg::ACK_SETUP_RST;
      cfg_q.ack_tmo    <= i2cm_pkg::ACK_TMO_RST;
    end else if (we_i) begin
      unique case (i2cm_pkg::reg_e'(idx_i))
        i2cm_pkg::REG_HALF_BIT:   cfg_q.half_bit   <= wdata_i;
        i2cm_pkg::REG_START_STOP: cfg_q.start_stop <= wdata_i;
        i2cm_pkg::REG_ACK_SETUP:  cfg_q.ack_setup  <= wdata_i;
        i2cm_pkg::REG_ACK_TMO:    cfg_q.ack_tmo    <= wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/i2cm_seq.sv
// Bus sequencer of the I2C master byte engine: one step per accepted tick.
// Depends on i2cm_pkg for the phase, op and struct types.
module i2cm_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  i2cm_pkg::cmd_t cmd_i,
  input  i2cm_pkg::cfg_t cfg_i,
  output i2cm_pkg::res_t res_o
);

  localparam int BCW = i2cm_pkg::BIT_CNT_W;
  localparam int TW  = i2cm_pkg::TICK_W;
  localparam int BB  = i2cm_pkg::BYTE_BITS;

  i2cm_pkg::phase_e phase_q, phase_d;
  logic [BCW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [BB-1:0]    shift_q, shift_d;
  logic [BB-1:0]    rx_q, rx_d;
  logic [TW-1:0]    wait_q, wait_d;
  logic [TW-1:0]    tmo_q, tmo_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic             drive_q, drive_d;
  logic             nack_q, nack_d;
  logic             ack_lat_q, ack_lat_d;
  logic             done_q, done_d;

  // A timing register written as zero behaves as one.
  function automatic logic [TW-1:0] at_least_one(input logic [TW-1:0] ticks);
    at_least_one = (ticks == '0) ? TW'(1) : ticks;
  endfunction

  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    rx_d      = rx_q;
    wait_d    = wait_q;
    tmo_d     = tmo_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    drive_d   = drive_q;
    nack_d    = nack_q;
    ack_lat_d = ack_lat_q;
    done_d    = done_q;
    if (step_i) begin
      done_d = 1'b0;
      if (phase_q == i2cm_pkg::PH_IDLE) begin
        unique case (cmd_i.op)
          i2cm_pkg::OP_START: begin
            drive_d = 1'b1;
            sda_d   = 1'b1;
            scl_d   = 1'b1;
            phase_d = i2cm_pkg::PH_ST1;
            wait_d  = at_least_one(cfg_i.start_stop);
          end
          i2cm_pkg::OP_STOP: begin
            drive_d = 1'b1;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            phase_d = i2cm_pkg::PH_SP1;
            wait_d  = at_least_one(cfg_i.start_stop);
          end
          i2cm_pkg::OP_WRITE: begin
            drive_d   = 1'b1;
            scl_d     = 1'b0;
            nack_d    = 1'b0;
            bit_cnt_d = '0;
            sda_d     = cmd_i.tx_byte[BB-1];
            shift_d   = {cmd_i.tx_byte[BB-2:0], 1'b0};
            phase_d   = i2cm_pkg::PH_WLO1;
            wait_d    = at_least_one(cfg_i.half_bit);
          end
          i2cm_pkg::OP_READ: begin
            drive_d   = 1'b0;
            scl_d     = 1'b0;
            shift_d   = '0;
            bit_cnt_d = '0;
            ack_lat_d = cmd_i.send_ack;
            phase_d   = i2cm_pkg::PH_RLO;
            wait_d    = at_least_one(cfg_i.half_bit);
          end
          default: ;
        endcase
      end else if (phase_q == i2cm_pkg::PH_POLL) begin
        if (!cmd_i.sda_in) begin
          scl_d   = 1'b0;
          phase_d = i2cm_pkg::PH_IDLE;
          done_d  = 1'b1;
        end else if (tmo_q >= cfg_i.ack_tmo) begin
          // No acknowledge in time: abort the write with a stop condition.
          nack_d  = 1'b1;
          drive_d = 1'b1;
          scl_d   = 1'b0;
          sda_d   = 1'b0;
          phase_d = i2cm_pkg::PH_SP1;
          wait_d  = at_least_one(cfg_i.start_stop);
        end else begin
          tmo_d = tmo_q + TW'(1);
        end
      end else if (wait_q > TW'(1)) begin
        wait_d = wait_q - TW'(1);
      end else begin
        unique case (phase_q)
          i2cm_pkg::PH_ST1: begin
            sda_d   = 1'b0;
            phase_d = i2cm_pkg::PH_ST2;
            wait_d  = at_least_one(cfg_i.start_stop);
          end
          i2cm_pkg::PH_ST2: begin
            scl_d   = 1'b0;
            phase_d = i2cm_pkg::PH_IDLE;
            done_d  = 1'b1;
          end
          i2cm_pkg::PH_SP1: begin
            scl_d   = 1'b1;
            sda_d   = 1'b1;
            phase_d = i2cm_pkg::PH_SP2;
            wait_d  = at_least_one(cfg_i.start_stop);
          end
          i2cm_pkg::PH_SP2: begin
            phase_d = i2cm_pkg::PH_IDLE;
            done_d  = 1'b1;
          end
          i2cm_pkg::PH_WLO1: begin
            scl_d   = 1'b1;
            phase_d = i2cm_pkg::PH_WHI;
            wait_d  = at_least_one(cfg_i.half_bit);
          end
          i2cm_pkg::PH_WHI: begin
            scl_d   = 1'b0;
            phase_d = i2cm_pkg::PH_WLO2;
            wait_d  = at_least_one(cfg_i.half_bit);
          end
          i2cm_pkg::PH_WLO2: begin
            bit_cnt_d = bit_cnt_q + BCW'(1);
            if (bit_cnt_q < BCW'(BB - 1)) begin
              sda_d   = shift_q[BB-1];
              shift_d = {shift_q[BB-2:0], 1'b0};
              phase_d = i2cm_pkg::PH_WLO1;
              wait_d  = at_least_one(cfg_i.half_bit);
            end else begin
              drive_d = 1'b0;
              sda_d   = 1'b1;
              phase_d = i2cm_pkg::PH_A1;
              wait_d  = at_least_one(cfg_i.ack_setup);
            end
          end
          i2cm_pkg::PH_A1: begin
            scl_d   = 1'b1;
            phase_d = i2cm_pkg::PH_A2;
            wait_d  = at_least_one(cfg_i.ack_setup);
          end
          i2cm_pkg::PH_A2: begin
            tmo_d   = '0;
            phase_d = i2cm_pkg::PH_POLL;
          end
          i2cm_pkg::PH_RLO: begin
            scl_d     = 1'b1;
            shift_d   = {shift_q[BB-2:0], cmd_i.sda_in};
            bit_cnt_d = bit_cnt_q + BCW'(1);
            phase_d   = i2cm_pkg::PH_RHI;
            wait_d    = at_least_one(cfg_i.half_bit);
          end
          i2cm_pkg::PH_RHI: begin
            scl_d  = 1'b0;
            wait_d = at_least_one(cfg_i.half_bit);
            if (bit_cnt_q < BCW'(BB)) begin
              phase_d = i2cm_pkg::PH_RLO;
            end else begin
              rx_d    = shift_q;
              drive_d = 1'b1;
              sda_d   = !ack_lat_q;
              phase_d = i2cm_pkg::PH_K1;
            end
          end
          i2cm_pkg::PH_K1: begin
            scl_d   = 1'b1;
            phase_d = i2cm_pkg::PH_K2;
            wait_d  = at_least_one(cfg_i.half_bit);
          end
          i2cm_pkg::PH_K2: begin
            scl_d   = 1'b0;
            phase_d = i2cm_pkg::PH_IDLE;
            done_d  = 1'b1;
          end
          default: phase_d = i2cm_pkg::PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= i2cm_pkg::PH_IDLE;
      bit_cnt_q <= '0;
      shift_q   <= '0;
      rx_q      <= '0;
      wait_q    <= '0;
      tmo_q     <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      drive_q   <= 1'b1;
      nack_q    <= 1'b0;
      ack_lat_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      rx_q      <= rx_d;
      wait_q    <= wait_d;
      tmo_q     <= tmo_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      drive_q   <= drive_d;
      nack_q    <= nack_d;
      ack_lat_q <= ack_lat_d;
      done_q    <= done_d;
    end
  end

  always_comb begin
    res_o.scl_level   = scl_q;
    res_o.sda_level   = sda_q;
    res_o.sda_drive   = drive_q;
    res_o.busy_res    = (phase_q != i2cm_pkg::PH_IDLE);
    res_o.done_res    = done_q;
    res_o.rx_byte     = rx_q;
    res_o.ack_missing = nack_q;
  end

endmodule

FILE: design/i2c_master_byte_engine.sv
// Channel   Dir  Payload                                        Handshake
// cmd_i     in   op, tx_byte, send_ack, sda_in                  valid/ready
// res_o     out  scl_level, sda_level, sda_drive, busy_res,     valid/ready
//                done_res, rx_byte, ack_missing
// cfg_*_i   in   cfg_idx_i, cfg_wdata_i                         cfg_we_i
//
// Each accepted word is one bus tick; its result word appears the next cycle.
// The sequencer registers double as the result register, so a new word is taken
// in every cycle in which the result is empty or being taken.
// A stalled result holds the sequencer; the command side then sees ready low.
// Reset is asynchronous and active low and leaves both lines driven high and the sequencer idle.
// Top level of the I2C master byte engine.
// Depends on i2cm_pkg, i2cm_if, i2cm_cfg and i2cm_seq.
module i2c_master_byte_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  i2cm_cmd_if.sink                       cmd_i,
  i2cm_res_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [i2cm_pkg::TICK_W-1:0]    cfg_wdata_i
);

  i2cm_pkg::cfg_t cfg;
  i2cm_pkg::cmd_t cmd;
  i2cm_pkg::res_t res;
  logic           out_valid_q, out_valid_d;
  logic           accept;

  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    cmd.op       = cmd_i.op;
    cmd.tx_byte  = cmd_i.tx_byte;
    cmd.send_ack = cmd_i.send_ack;
    cmd.sda_in   = cmd_i.sda_in;
  end

  i2cm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  i2cm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .cmd_i  (cmd),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.scl_level   = res.scl_level;
  assign res_o.sda_level   = res.sda_level;
  assign res_o.sda_drive   = res.sda_drive;
  assign res_o.busy_res    = res.busy_res;
  assign res_o.done_res    = res.done_res;
  assign res_o.rx_byte     = res.rx_byte;
  assign res_o.ack_missing = res.ack_missing;

endmodule

FILE: design/i2cm_checker.sv
// Port-level checks of the I2C master byte engine, bound to its top level.
// Depends on assert_macros.svh and the top level's ports.
`include "assert_macros.svh"

module i2cm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic busy_i,
  input logic done_i
);

  // A finished command reports idle in the same word.
  `ASSERT_NEVER(a_done_not_busy, clk_i, rst_ni, out_valid_i && done_i && busy_i)

  // Every accepted command word yields a result word in the next cycle.
  `ASSERT_AT(a_accept_gives_result, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> out_valid_i)

  // A held result blocks the command side.
  `ASSERT_AT(a_stall_blocks_input, clk_i, rst_ni, (out_valid_i && !out_ready_i) |-> !in_ready_i)

  // With no result pending the engine always takes a word.
  `ASSERT_AT(a_empty_is_ready, clk_i, rst_ni, !out_valid_i |-> in_ready_i)

  // A result stays offered until it is taken.
  `ASSERT_AT(a_result_held, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i)

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .busy_i      (res_o.busy_res),
  .done_i      (res_o.done_res)
);

FILE: tb/sv/tb.sv
// Self-checking testbench of the I2C master byte engine: drives bus ticks and
// compares every line-state word with a predictor of the sequencer.
// Depends on i2cm_pkg, the i2cm_cmd_if / i2cm_res_if interfaces and the block.
`timescale 1ns / 100ps

module tb;
  import i2cm_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 100;
  localparam int NEVER_ACK   = 1000;

  // Predicts the line state that the sequencer reports after each tick.
  class bus_line_predictor;
    cfg_t       cfg;
    phase_e     ph;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [7:0] wait_cnt;
    logic [7:0] poll_cnt;
    logic [7:0] rx;
    logic       scl, sda, drv, nack, ack_sel;
    res_t       line_words_q[$];
    int         words_seen;

    function new();
      cfg.half_bit   = HALF_BIT_RST;
      cfg.start_stop = START_STOP_RST;
      cfg.ack_setup  = ACK_SETUP_RST;
      cfg.ack_tmo    = ACK_TMO_RST;
      ph = PH_IDLE;
      bit_cnt = '0;
      shreg = '0;
      wait_cnt = '0;
      poll_cnt = '0;
      rx = '0;
      scl = 1'b1;
      sda = 1'b1;
      drv = 1'b1;
      nack = 1'b0;
      ack_sel = 1'b0;
      words_seen = 0;
    endfunction

    function void write_reg(reg_e idx, logic [7:0] v);
      case (idx)
        REG_HALF_BIT:   cfg.half_bit = v;
        REG_START_STOP: cfg.start_stop = v;
        REG_ACK_SETUP:  cfg.ack_setup = v;
        REG_ACK_TMO:    cfg.ack_tmo = v;
        default: ;
      endcase
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    // A timing register written as zero still waits one tick.
    function void enter(phase_e p, logic [7:0] ticks);
      ph = p;
      wait_cnt = (ticks == 8'd0) ? 8'd1 : ticks;
    endfunction

    function void shift_out();
      sda = shreg[7];
      shreg = shreg << 1;
    endfunction

    function void take_tick(cmd_t c);
      res_t r;
      logic fin;
      fin = 1'b0;
      if (ph == PH_IDLE) begin
        case (c.op)
          OP_START: begin
            drv = 1'b1; sda = 1'b1; scl = 1'b1;
            enter(PH_ST1, cfg.start_stop);
          end
          OP_STOP: begin
            drv = 1'b1; scl = 1'b0; sda = 1'b0;
            enter(PH_SP1, cfg.start_stop);
          end
          OP_WRITE: begin
            drv = 1'b1; scl = 1'b0; nack = 1'b0;
            shreg = c.tx_byte;
            bit_cnt = '0;
            shift_out();
            enter(PH_WLO1, cfg.half_bit);
          end
          OP_READ: begin
            drv = 1'b0; scl = 1'b0; shreg = '0; bit_cnt = '0;
            ack_sel = c.send_ack;
            enter(PH_RLO, cfg.half_bit);
          end
          default: ;
        endcase
      end else if (ph == PH_POLL) begin
        if (!c.sda_in) begin
          scl = 1'b0; ph = PH_IDLE; fin = 1'b1;
        end else if (poll_cnt >= cfg.ack_tmo) begin
          // No acknowledge in time: abort with a stop condition.
          nack = 1'b1; drv = 1'b1; scl = 1'b0; sda = 1'b0;
          enter(PH_SP1, cfg.start_stop);
        end else begin
          poll_cnt++;
        end
      end else if (wait_cnt > 8'd1) begin
        wait_cnt--;
      end else begin
        case (ph)
          PH_ST1: begin sda = 1'b0; enter(PH_ST2, cfg.start_stop); end
          PH_ST2: begin scl = 1'b0; ph = PH_IDLE; fin = 1'b1; end
          PH_SP1: begin scl = 1'b1; sda = 1'b1; enter(PH_SP2, cfg.start_stop); end
          PH_SP2: begin ph = PH_IDLE; fin = 1'b1; end
          PH_WLO1: begin scl = 1'b1; enter(PH_WHI, cfg.half_bit); end
          PH_WHI: begin scl = 1'b0; enter(PH_WLO2, cfg.half_bit); end
          PH_WLO2: begin
            bit_cnt++;
            if (bit_cnt < BYTE_BITS) begin
              shift_out();
              enter(PH_WLO1, cfg.half_bit);
            end else begin
              drv = 1'b0; sda = 1'b1;
              enter(PH_A1, cfg.ack_setup);
            end
          end
          PH_A1: begin scl = 1'b1; enter(PH_A2, cfg.ack_setup); end
          PH_A2: begin poll_cnt = '0; ph = PH_POLL; end
          PH_RLO: begin
            scl = 1'b1;
            shreg = {shreg[6:0], c.sda_in};
            bit_cnt++;
            enter(PH_RHI, cfg.half_bit);
          end
          PH_RHI: begin
            scl = 1'b0;
            if (bit_cnt < BYTE_BITS) begin
              enter(PH_RLO, cfg.half_bit);
            end else begin
              rx = shreg;
              drv = 1'b1;
              sda = ~ack_sel;
              enter(PH_K1, cfg.half_bit);
            end
          end
          PH_K1: begin scl = 1'b1; enter(PH_K2, cfg.half_bit); end
          PH_K2: begin scl = 1'b0; ph = PH_IDLE; fin = 1'b1; end
          default: ph = PH_IDLE;
        endcase
      end
      r.scl_level   = scl;
      r.sda_level   = sda;
      r.sda_drive   = drv;
      r.busy_res    = (ph != PH_IDLE);
      r.done_res    = fin;
      r.rx_byte     = rx;
      r.ack_missing = nack;
      line_words_q.push_back(r);
    endfunction

    // Returns 1 when the word does not match the oldest prediction or nothing is predicted.
    function bit match_word(res_t got, output string msg);
      res_t  want;
      string diff;
      diff = "";
      words_seen++;
      if (line_words_q.size() == 0) begin
        msg = $sformatf("word %0d arrived with nothing predicted", words_seen);
        return 1'b1;
      end
      want = line_words_q.pop_front();
      if (got.scl_level !== want.scl_level) diff = {diff, " scl_level"};
      if (got.sda_level !== want.sda_level) diff = {diff, " sda_level"};
      if (got.sda_drive !== want.sda_drive) diff = {diff, " sda_drive"};
      if (got.busy_res !== want.busy_res) diff = {diff, " busy_res"};
      if (got.done_res !== want.done_res) diff = {diff, " done_res"};
      if (got.rx_byte !== want.rx_byte) diff = {diff, " rx_byte"};
      if (got.ack_missing !== want.ack_missing) diff = {diff, " ack_missing"};
      if (diff == "") begin
        msg = "";
        return 1'b0;
      end
      msg = $sformatf("word %0d:%s differ, got %h want %h", words_seen, diff, got, want);
      return 1'b1;
    endfunction
  endclass

  typedef struct {
    logic [OP_W-1:0] op;
    logic [7:0]      tx;
    logic            sack;
    int              ack_delay;
  } bus_cmd_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [TICK_W-1:0]    cfg_wdata;

  i2cm_cmd_if cmd();
  i2cm_res_if res();

  i2c_master_byte_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  bus_line_predictor pred = new();
  bus_cmd_t          cmd_plan_q[$];
  int                errors = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  bit                hold_req = 1'b0;
  int                quiet_cycles = 0;
  int                ack_delay_now = 0;
  int                polls_given = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report(string msg);
    errors++;
    $display("tb: mismatch: %s", msg);
  endtask

  // Offers one word and returns at the edge where it is taken; valid stays high.
  task automatic send_word(cmd_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd.valid    <= 1'b1;
    cmd.op       <= w.op;
    cmd.tx_byte  <= w.tx_byte;
    cmd.send_ack <= w.send_ack;
    cmd.sda_in   <= w.sda_in;
    @(posedge clk_i);
    while (!cmd.ready) @(posedge clk_i);
    pred.take_tick(w);
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (pred.line_words_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    pred.write_reg(idx, v);
  endtask

  task automatic set_config(logic [7:0] hb, logic [7:0] ss, logic [7:0] as, logic [7:0] tmo);
    drain();
    repeat (4) @(posedge clk_i);
    write_reg(REG_HALF_BIT, hb);
    write_reg(REG_START_STOP, ss);
    write_reg(REG_ACK_SETUP, as);
    write_reg(REG_ACK_TMO, tmo);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    set_config(8'($urandom_range(2)), 8'($urandom_range(1, 2)), 8'($urandom_range(3)),
               8'($urandom_range(6)));
  endtask

  task automatic add_cmd(logic [OP_W-1:0] op, logic [7:0] tx, logic sack, int delay);
    bus_cmd_t p;
    p.op = op;
    p.tx = tx;
    p.sack = sack;
    p.ack_delay = delay;
    cmd_plan_q.push_back(p);
  endtask

  // Polls answered with one before the acknowledge; boundaries around the timeout.
  function automatic int pick_ack_delay();
    int tmo;
    int r;
    tmo = pred.cfg.ack_tmo;
    r = $urandom_range(9);
    if (r < 4) return 0;
    if (r < 6) return $urandom_range(1, 3);
    if (r == 6) return tmo;
    if (r == 7) return tmo + 1;
    if (r == 8) return $urandom_range(tmo);
    return NEVER_ACK;
  endfunction

  task automatic add_sequences(int n);
    int k;
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) begin
        add_cmd(OP_START, 8'($urandom), 1'($urandom), 0);
        add_cmd(OP_WRITE, 8'($urandom), 1'($urandom), pick_ack_delay());
        k = $urandom_range(2);
        repeat (k) begin
          if ($urandom_range(1) == 0) add_cmd(OP_WRITE, 8'($urandom), 1'($urandom),
                                              pick_ack_delay());
          else add_cmd(OP_READ, 8'($urandom), 1'($urandom), 0);
        end
        add_cmd(OP_STOP, 8'($urandom), 1'($urandom), 0);
      end else begin
        add_cmd(OP_W'($urandom_range(OP_START, OP_READ)), 8'($urandom), 1'($urandom),
                pick_ack_delay());
      end
    end
  endtask

  // Feeds ticks until every planned command has run and the engine is idle again.
  task automatic play_plan();
    cmd_t     w;
    bus_cmd_t p;
    int       idx;
    while (cmd_plan_q.size() > 0 || pred.busy()) begin
      w.op       = OP_W'($urandom_range(7));
      w.tx_byte  = 8'($urandom);
      w.send_ack = 1'($urandom);
      w.sda_in   = 1'($urandom);
      if (!pred.busy()) begin
        if ($urandom_range(4) == 0) begin
          // Idle noise: no command, or one of the unused op codes.
          idx = $urandom_range(3);
          w.op = (idx == 0) ? OP_NONE : OP_W'(OP_READ + idx);
        end else begin
          p = cmd_plan_q.pop_front();
          w.op = p.op;
          w.tx_byte = p.tx;
          w.send_ack = p.sack;
          if (p.op == OP_WRITE) begin
            ack_delay_now = p.ack_delay;
            polls_given = 0;
          end
        end
      end else if (pred.ph == PH_POLL) begin
        w.sda_in = (polls_given >= ack_delay_now) ? 1'b0 : 1'b1;
        polls_given++;
      end
      send_word(w);
    end
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Receiver: takes result words with random or long stalls and checks them.
  initial begin
    res_t  got;
    string msg;
    int    hold_left;
    hold_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res.valid && res.ready) begin
        got.scl_level   = res.scl_level;
        got.sda_level   = res.sda_level;
        got.sda_drive   = res.sda_drive;
        got.busy_res    = res.busy_res;
        got.done_res    = res.done_res;
        got.rx_byte     = res.rx_byte;
        got.ack_missing = res.ack_missing;
        if (pred.match_word(got, msg)) report(msg);
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd.valid && cmd.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: watchdog expired, no word moved for %0d cycles", QUIET_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    cmd.valid    <= 1'b0;
    cmd.op       <= OP_NONE;
    cmd.tx_byte  <= '0;
    cmd.send_ack <= 1'b0;
    cmd.sda_in   <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_HALF_BIT;
    cfg_wdata    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset timing: a late acknowledge, a read with ACK and
    // the unused ops.
    set_idling(0, 0);
    add_cmd(OP_START, 8'h00, 1'b0, 0);
    add_cmd(OP_WRITE, 8'h00, 1'b0, 2);
    add_cmd(OP_READ, 8'h00, 1'b1, 0);
    add_cmd(OP_W'(OP_READ + 1), 8'h5A, 1'b1, 0);
    add_cmd(OP_W'(OP_READ + 2), 8'hA5, 1'b0, 0);
    add_cmd(OP_W'(OP_READ + 3), 8'h3C, 1'b1, 0);
    add_cmd(OP_STOP, 8'h00, 1'b0, 0);
    play_plan();

    // Zero in every register: one-tick waits, abort on the first failed poll,
    // byte extremes and a read with NACK.
    set_config(8'd0, 8'd0, 8'd0, 8'd0);
    add_cmd(OP_START, 8'h00, 1'b0, 0);
    add_cmd(OP_WRITE, 8'hFF, 1'b0, NEVER_ACK);
    add_cmd(OP_WRITE, 8'h00, 1'b0, 0);
    add_cmd(OP_READ, 8'h00, 1'b0, 0);
    add_cmd(OP_STOP, 8'h00, 1'b0, 0);
    play_plan();

    // Fastest timing; the receiver holds off long enough to stall the input.
    set_config(8'd1, 8'd1, 8'd1, 8'd1);
    set_idling(0, 0);
    hold_req = 1'b1;
    add_sequences(1);
    play_plan();

    random_config();
    set_idling(53, 0);
    add_sequences(1);
    play_plan();

    // The sender pauses midway until every word is back.
    set_config(8'd1, 8'd2, 8'd2, 8'd5);
    set_idling(0, 53);
    add_sequences(1);
    play_plan();
    drain();
    add_sequences(1);
    play_plan();

    random_config();
    set_idling(32, 32);
    add_sequences(1);
    play_plan();

    // Largest timeout, answered after a few polls.
    set_config(8'd1, 8'd1, 8'd1, 8'd255);
    set_idling(0, 0);
    add_cmd(OP_START, 8'h00, 1'b0, 0);
    add_cmd(OP_WRITE, 8'hA5, 1'b0, 2);
    add_cmd(OP_STOP, 8'h00, 1'b0, 0);
    play_plan();

    drain();
    repeat (10) @(posedge clk_i);
    if (pred.line_words_q.size() != 0)
      report($sformatf("%0d predicted words never arrived", pred.line_words_q.size()));
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
